>>> hw/rtl/fbpa_pkg.sv
// Shared constants, codes and types for the fixed block pool allocator.
`timescale 1ns / 1ps
package fbpa_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int ADDR_W     = 32;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
	localparam int LG_W       = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
	localparam logic [LG_W-1:0]   LG_MIN    = LG_W'(2);
	localparam logic [LG_W-1:0]   LG_MAX    = LG_W'(16);
	localparam logic [LG_W-1:0]   LG_RESET  = LG_W'(4);

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS     = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REBUILD = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_ADDR = 2'd2
	} status_t;

	// Control of the shared add/shift unit.
	typedef struct packed {
		logic            shift_right;
		logic [LG_W-1:0] shamt;
		logic            carry_in;
	} alu_ctl_t;

endpackage

>>> hw/rtl/fbpa_if.sv
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps
interface fbpa_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [fbpa_pkg::ADDR_W-1:0] free_address;

	modport source (output valid, output op, output free_address, input ready);
	modport sink   (input valid, input op, input free_address, output ready);
endinterface

interface fbpa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [fbpa_pkg::ADDR_W-1:0] block_address;
	logic [1:0]                  status;
	logic [fbpa_pkg::LINK_W-1:0] allocated_count;
	logic [fbpa_pkg::LINK_W-1:0] peak_count;

	modport source (output valid, output block_address, output status,
		output allocated_count, output peak_count, input ready);
	modport sink   (input valid, input block_address, input status,
		input allocated_count, input peak_count, output ready);
endinterface

interface fbpa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fbpa_pkg::CFG_IDX_W-1:0] index;
	logic [fbpa_pkg::ADDR_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/fbpa_alu.sv
// Shared add/shift unit: a + shift(b) + carry, used for block address and offset math.
`timescale 1ns / 1ps
module fbpa_alu (
	input  logic [fbpa_pkg::ADDR_W-1:0] a,
	input  logic [fbpa_pkg::ADDR_W-1:0] b,
	input  fbpa_pkg::alu_ctl_t          ctl,
	output logic [fbpa_pkg::ADDR_W-1:0] sum
);
	import fbpa_pkg::*;

	logic [ADDR_W-1:0] b_shifted;

	// Shift the second operand, then add with carry; wraps modulo 2^ADDR_W
	always_comb begin
		if (ctl.shift_right) begin
			b_shifted = b >> ctl.shamt;
		end else begin
			b_shifted = b << ctl.shamt;
		end
		sum = a + b_shifted + ADDR_W'(ctl.carry_in);
	end

endmodule

>>> hw/rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: sequencer, link RAM, shared ALU, registers.
`timescale 1ns / 1ps
// Fixed-size block pool with a LIFO free list held in a 256-entry link RAM. One request
// is worked at a time and req.ready is high only while the sequencer is idle. From the
// transfer of a request to its result landing in the output register: allocate runs
// link RAM read, head update, output; allocate on an empty pool and an unused op go
// straight to output; free runs subtract, then shift and alignment check in the shared
// add/shift unit, then range check with the link write, then output; rebuild writes
// one link RAM entry per cycle, 256 entries, then output. The output register holds a
// result until rsp takes it; the next request is accepted once the previous result has
// moved into it. After reset the block runs a pass that chains all 256 link RAM entries
// before the first request is accepted; configuration writes are taken at any time
// (cfg.ready is always high) and must only be issued while no request is in flight.
module fixed_block_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	fbpa_req_if.sink    req,
	fbpa_rsp_if.source  rsp,
	fbpa_cfg_if.sink    cfg
);
	import fbpa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_UPD,
		S_FREE_SUB,
		S_FREE_SHR,
		S_FREE_UPD,
		S_REBUILD,
		S_OUT
	} state_t;

	state_t              state_q;
	logic                boot_q;
	logic [ADDR_W-1:0]   pool_base_q;
	logic [LG_W-1:0]     block_log2_q;
	logic [LINK_W-1:0]   blocks_q;

	logic [LINK_W-1:0]   head_q;
	logic [LINK_W-1:0]   live_q;
	logic [LINK_W-1:0]   peak_q;
	logic [LINK_W-1:0]   n_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [ADDR_W-1:0]   free_addr_q;
	logic [ADDR_W-1:0]   off_q;
	logic [ADDR_W-1:0]   blk_q;
	logic                aligned_q;
	logic [ADDR_W-1:0]   res_addr_q;
	status_t             res_status_q;

	logic                rsp_valid_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	status_t             rsp_status_q;
	logic [LINK_W-1:0]   rsp_live_q;
	logic [LINK_W-1:0]   rsp_peak_q;

	logic [LG_W-1:0]     eff_lg;
	logic [LINK_W-1:0]   eff_n;
	logic [ADDR_W-1:0]   low_mask;
	logic [LINK_W-1:0]   ptr_next;
	logic [LINK_W-1:0]   sweep_link;
	logic [LINK_W-1:0]   live_inc;
	logic                out_free;

	logic [ADDR_W-1:0]   alu_a;
	logic [ADDR_W-1:0]   alu_b;
	alu_ctl_t            alu_ctl;
	logic [ADDR_W-1:0]   alu_sum;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [LINK_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [LINK_W-1:0]   ram_rdata;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			block_log2_q <= LG_RESET;
			blocks_q     <= LINK_W'(MAX_BLOCKS);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_POOL_BASE:  pool_base_q  <= cfg.data;
				CFG_BLOCK_LOG2: block_log2_q <= cfg.data[LG_W-1:0];
				CFG_BLOCKS:     blocks_q     <= cfg.data[LINK_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp block size and block count to their legal ranges
	always_comb begin
		if (block_log2_q < LG_MIN) begin
			eff_lg = LG_MIN;
		end else if (block_log2_q > LG_MAX) begin
			eff_lg = LG_MAX;
		end else begin
			eff_lg = block_log2_q;
		end
		if (blocks_q == '0) begin
			eff_n = LINK_W'(1);
		end else if (blocks_q > LINK_W'(MAX_BLOCKS)) begin
			eff_n = LINK_W'(MAX_BLOCKS);
		end else begin
			eff_n = blocks_q;
		end
	end

	assign low_mask   = ~({ADDR_W{1'b1}} << eff_lg);
	assign ptr_next   = {1'b0, ptr_q} + LINK_W'(1);
	assign sweep_link = (ptr_next < n_q) ? ptr_next : NULL_LINK;
	assign live_inc   = (live_q < LINK_W'(MAX_BLOCKS)) ? live_q + LINK_W'(1) : live_q;
	assign out_free   = !rsp_valid_q || rsp.ready;

	// Operand selection for the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_ctl = '{shift_right: 1'b0, shamt: '0, carry_in: 1'b0};
		case (state_q)
			S_ALLOC_RD: begin
				alu_a         = pool_base_q;
				alu_b         = ADDR_W'(head_q[IDX_W-1:0]);
				alu_ctl.shamt = eff_lg;
			end
			S_FREE_SUB: begin
				alu_a            = free_addr_q;
				alu_b            = ~pool_base_q;
				alu_ctl.carry_in = 1'b1;
			end
			S_FREE_SHR: begin
				alu_b               = off_q;
				alu_ctl.shift_right = 1'b1;
				alu_ctl.shamt       = eff_lg;
			end
			default: ;
		endcase
	end

	fbpa_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.ctl (alu_ctl),
		.sum (alu_sum)
	);

	// Link RAM ports: sweep and free write, allocate reads
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = sweep_link;
		case (state_q)
			S_REBUILD: ram_we = 1'b1;
			S_FREE_UPD: begin
				ram_we    = aligned_q && (blk_q < ADDR_W'(eff_n));
				ram_waddr = blk_q[IDX_W-1:0];
				ram_wdata = head_q;
			end
			default: ;
		endcase
	end

	assign ram_re = (state_q == S_ALLOC_RD);

	fbpa_ram #(
		.WIDTH (LINK_W),
		.DEPTH (MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);

	// Sequencer, list state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_REBUILD;
			boot_q       <= 1'b1;
			head_q       <= '0;
			live_q       <= '0;
			peak_q       <= '0;
			n_q          <= LINK_W'(MAX_BLOCKS);
			ptr_q        <= '0;
			free_addr_q  <= '0;
			off_q        <= '0;
			blk_q        <= '0;
			aligned_q    <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_addr_q   <= '0;
			rsp_status_q <= ST_OK;
			rsp_live_q   <= '0;
			rsp_peak_q   <= '0;
		end else begin
			// Raise valid when a result lands, drop it once taken
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						free_addr_q  <= req.free_address;
						res_addr_q   <= '0;
						res_status_q <= ST_OK;
						case (req.op)
							OP_ALLOC: begin
								if (head_q >= NULL_LINK) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_OUT;
								end else begin
									state_q <= S_ALLOC_RD;
								end
							end
							OP_FREE: state_q <= S_FREE_SUB;
							OP_REBUILD: begin
								n_q     <= eff_n;
								ptr_q   <= '0;
								state_q <= S_REBUILD;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ALLOC_RD: begin
					res_addr_q <= alu_sum;
					state_q    <= S_ALLOC_UPD;
				end
				S_ALLOC_UPD: begin
					head_q  <= ram_rdata;
					live_q  <= live_inc;
					if (live_inc > peak_q) begin
						peak_q <= live_inc;
					end
					state_q <= S_OUT;
				end
				S_FREE_SUB: begin
					off_q   <= alu_sum;
					state_q <= S_FREE_SHR;
				end
				S_FREE_SHR: begin
					blk_q     <= alu_sum;
					aligned_q <= ((off_q & low_mask) == '0);
					state_q   <= S_FREE_UPD;
				end
				S_FREE_UPD: begin
					if (aligned_q && (blk_q < ADDR_W'(eff_n))) begin
						head_q <= {1'b0, blk_q[IDX_W-1:0]};
						if (live_q != '0) begin
							live_q <= live_q - LINK_W'(1);
						end
					end else begin
						res_status_q <= ST_BAD_ADDR;
					end
					state_q <= S_OUT;
				end
				S_REBUILD: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (ptr_q == IDX_W'(MAX_BLOCKS - 1)) begin
						head_q <= '0;
						live_q <= '0;
						peak_q <= '0;
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					// Hold until the output register is free
					if (out_free) begin
						rsp_addr_q   <= res_addr_q;
						rsp_status_q <= res_status_q;
						rsp_live_q   <= live_q;
						rsp_peak_q   <= peak_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.block_address   = rsp_addr_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.allocated_count = rsp_live_q;
	assign rsp.peak_count      = rsp_peak_q;

endmodule
